[sv/mre_pkg.sv]
package mre_pkg;

  localparam int unsigned OpW  = 2;
  localparam int unsigned StW  = 3;

  typedef enum logic [1:0] {
    OP_SEND = 2'd0,
    OP_RECV = 2'd1,
    OP_INT  = 2'd2,
    OP_BAD  = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_DELIVERED = 3'd0,
    ST_BLOCKED   = 3'd1,
    ST_PENDING   = 3'd2,
    ST_DEADLOCK  = 3'd3,
    ST_INVALID   = 3'd4
  } status_e;

  // Kinds of list walk performed by the shared walker.
  typedef enum logic [1:0] {
    WK_CHAIN   = 2'd0,
    WK_TAIL    = 2'd1,
    WK_UNLINK  = 2'd2
  } walk_e;

endpackage

[sv/mre_if.sv]
interface mre_req_if #(
  parameter int unsigned PW = 3,
  parameter int unsigned QW = 4,
  parameter int unsigned TW = 16,
  parameter int unsigned DW = 32
);
  logic          valid;
  logic          ready;
  logic [1:0]    operation;
  logic [PW-1:0] caller;
  logic [QW-1:0] peer;
  logic [TW-1:0] message_type;
  logic [DW-1:0] message_data;

  modport source (output valid, operation, caller, peer, message_type, message_data,
                  input ready);
  modport sink   (input valid, operation, caller, peer, message_type, message_data,
                  output ready);
endinterface

interface mre_rsp_if #(
  parameter int unsigned PW = 3,
  parameter int unsigned QW = 4,
  parameter int unsigned TW = 16,
  parameter int unsigned DW = 32
);
  logic          valid;
  logic          ready;
  logic [2:0]    status;
  logic [PW-1:0] receiver;
  logic [QW-1:0] sender;
  logic [TW-1:0] out_type;
  logic [DW-1:0] out_data;

  modport source (output valid, status, receiver, sender, out_type, out_data,
                  input ready);
  modport sink   (input valid, status, receiver, sender, out_type, out_data,
                  output ready);
endinterface

[sv/mre_walker.sv]
// Shared list walker: one link per cycle over the sender chain or a queue.
module mre_walker import mre_pkg::*; #(
  parameter int unsigned PROC_COUNT = 8,
  parameter int unsigned PW = 3,
  parameter int unsigned QW = 4
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  walk_e                 kind_i,
  input  logic [QW-1:0]         first_i,   // first node
  input  logic [PW-1:0]         key_i,     // node searched for
  input  logic [PROC_COUNT-1:0] sending_i,
  input  logic [PW-1:0]         target_i [PROC_COUNT],
  input  logic [QW-1:0]         next_i [PROC_COUNT],
  output logic                  done_o,
  output logic                  hit_o,     // found / deadlock
  output logic [QW-1:0]         node_o,    // last node (tail) or match
  output logic [QW-1:0]         prev_o     // predecessor of match
);
  localparam int unsigned CW = $clog2(PROC_COUNT + 1);

  logic          busy_q, busy_d, done_q, done_d, hit_q, hit_d;
  logic [QW-1:0] p_q, p_d, prev_q, prev_d;
  logic [CW-1:0] cnt_q, cnt_d;
  walk_e         kind_q;
  logic [PW-1:0] key_q;

  logic          pvalid;
  logic [PW-1:0] pidx;

  assign pvalid = p_q < QW'(PROC_COUNT);
  assign pidx   = p_q[PW-1:0];

  always_comb begin
    busy_d = busy_q; done_d = 1'b0; hit_d = hit_q;
    p_d = p_q; prev_d = prev_q; cnt_d = cnt_q;
    if (start_i) begin
      busy_d = 1'b1; hit_d = 1'b0; p_d = first_i;
      prev_d = QW'(PROC_COUNT); cnt_d = '0;
    end else if (busy_q) begin
      if (cnt_q == CW'(PROC_COUNT) || !pvalid) begin
        busy_d = 1'b0; done_d = 1'b1;
      end else begin
        case (kind_q)
          WK_CHAIN: begin
            if (!sending_i[pidx]) begin
              busy_d = 1'b0; done_d = 1'b1;
            end else if (target_i[pidx] == key_q) begin
              busy_d = 1'b0; done_d = 1'b1; hit_d = 1'b1;
            end else begin
              p_d = QW'(target_i[pidx]);
            end
          end
          WK_TAIL: begin
            if (next_i[pidx] >= QW'(PROC_COUNT)) begin
              busy_d = 1'b0; done_d = 1'b1; hit_d = 1'b1;
            end else begin
              p_d = next_i[pidx];
            end
          end
          WK_UNLINK: begin
            if (pidx == key_q) begin
              busy_d = 1'b0; done_d = 1'b1; hit_d = 1'b1;
            end else begin
              prev_d = p_q; p_d = next_i[pidx];
            end
          end
          default: begin
            busy_d = 1'b0; done_d = 1'b1;
          end
        endcase
        cnt_d = cnt_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; done_q <= 1'b0; hit_q <= 1'b0;
    end else begin
      busy_q <= busy_d; done_q <= done_d; hit_q <= hit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    p_q <= p_d; prev_q <= prev_d; cnt_q <= cnt_d;
    if (start_i) begin
      kind_q <= kind_i; key_q <= key_i;
    end
  end

  assign done_o = done_q;
  assign hit_o  = hit_q;
  assign node_o = p_q;
  assign prev_o = prev_q;
endmodule

[sv/message_rendezvous_engine_core.sv]
// Channel | dir | transfer when     | payload
// req     | in  | valid && ready    | operation, caller, peer, message_type, message_data
// rsp     | out | valid && ready    | status, receiver, sender, out_type, out_data
// cfg     | in  | cfg_we_i          | hard_int_type (no index)
//
// Requests are decoded in S_DEC; the earliest result is registered from there into the
//   result register. The shared walker advances
//   one list link per cycle (deadlock chain then queue tail, or queue unlink).
// One request at a time: req.ready is low from acceptance until the result
//   register is free again. A stalled rsp holds the result and the request side.
// Reset clears flags, pending bits and queue links; held payloads are undefined.
module message_rendezvous_engine_core import mre_pkg::*; #(
  parameter int unsigned PROC_COUNT = 8,
  parameter int unsigned DATA_WIDTH = 32,
  parameter int unsigned TYPE_WIDTH = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [TYPE_WIDTH-1:0] cfg_wdata_i,
  mre_req_if.sink               req,
  mre_rsp_if.source             rsp
);
  localparam int unsigned PW = (PROC_COUNT > 1) ? $clog2(PROC_COUNT) : 1;
  localparam int unsigned QW = $clog2(PROC_COUNT + 2);
  localparam logic [QW-1:0] AnyCode = QW'(PROC_COUNT);
  localparam logic [QW-1:0] IntCode = QW'(PROC_COUNT + 1);
  localparam logic [QW-1:0] Empty   = QW'(PROC_COUNT);

  // Sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DEC   = 3'd1;
  localparam logic [2:0] S_CHAIN = 3'd2;
  localparam logic [2:0] S_TAIL  = 3'd3;
  localparam logic [2:0] S_UNL   = 3'd4;
  localparam logic [2:0] S_OUT   = 3'd5;

  logic [2:0] st_q, st_d;

  // Process state
  logic [PROC_COUNT-1:0] snd_q, rcv_q, ipend_q;
  logic [PW-1:0]         tgt_q [PROC_COUNT];
  logic [QW-1:0]         rfrom_q [PROC_COUNT];
  logic [TYPE_WIDTH-1:0] htype_q [PROC_COUNT];
  logic [DATA_WIDTH-1:0] hdata_q [PROC_COUNT];
  logic [QW-1:0]         qhead_q [PROC_COUNT];
  logic [QW-1:0]         qnext_q [PROC_COUNT];
  logic [TYPE_WIDTH-1:0] hit_type_q;

  // Latched request
  logic [1:0]            op_q;
  logic [2:0]            caller_raw_q;
  logic [QW-1:0]         peer_q;
  logic [TYPE_WIDTH-1:0] ty_q;
  logic [DATA_WIDTH-1:0] da_q;
  logic [PW-1:0]         who_q;      // sender being taken on receive

  // Result register
  logic                  ovalid_q;
  logic [2:0]            ost_q;
  logic [PW-1:0]         orcv_q;
  logic [QW-1:0]         osnd_q;
  logic [TYPE_WIDTH-1:0] oty_q;
  logic [DATA_WIDTH-1:0] oda_q;

  // Walker
  logic          wk_start, wk_done, wk_hit;
  walk_e         wk_kind;
  logic [QW-1:0] wk_first, wk_node, wk_prev;
  logic [PW-1:0] wk_key;

  mre_walker #(.PROC_COUNT(PROC_COUNT), .PW(PW), .QW(QW)) u_walk (
    .clk_i, .rst_ni,
    .start_i(wk_start), .kind_i(wk_kind), .first_i(wk_first), .key_i(wk_key),
    .sending_i(snd_q), .target_i(tgt_q), .next_i(qnext_q),
    .done_o(wk_done), .hit_o(wk_hit),
    .node_o(wk_node), .prev_o(wk_prev)
  );

  logic [PW-1:0] cidx, pidx;
  logic          caller_ok;
  assign caller_ok = 32'(caller_raw_q) < PROC_COUNT;
  assign cidx = PW'(caller_raw_q);
  assign pidx = peer_q[PW-1:0];

  assign req.ready = (st_q == S_IDLE) && !ovalid_q;

  // Decode-stage decisions, all combinational from registered state.
  logic peer_proc, bad_common, rcv_match_send, int_wake;
  assign peer_proc  = peer_q < QW'(PROC_COUNT);
  assign bad_common = peer_q > IntCode || peer_q == QW'(cidx) || snd_q[cidx] || rcv_q[cidx];
  assign rcv_match_send = rcv_q[pidx] && (rfrom_q[pidx] == QW'(cidx) || rfrom_q[pidx] == AnyCode);
  assign int_wake = rcv_q[cidx] && (rfrom_q[cidx] == IntCode || rfrom_q[cidx] == AnyCode);

  // Next-state and result control (registers written in the clocked block).
  typedef struct packed {
    logic          emit;
    logic [2:0]    st;
    logic [PW-1:0] rcv;
    logic [QW-1:0] snd;
    logic          use_int;   // type = hard_int_type, data = 0
    logic          use_req;   // type/data from request
    logic          use_held;  // type/data from held of who_q
  } res_t;
  res_t res;

  always_comb begin
    st_d = st_q; res = '0;
    wk_start = 1'b0; wk_kind = WK_CHAIN; wk_first = peer_q; wk_key = cidx;
    case (st_q)
      S_IDLE: if (req.valid && req.ready) st_d = S_DEC;
      S_DEC: begin
        st_d = S_OUT; res.emit = 1'b1;
        if (op_q == OP_BAD || !caller_ok) res.st = ST_INVALID;
        else if (op_q == OP_INT) begin
          if (int_wake) begin
            res.st = ST_DELIVERED; res.rcv = cidx; res.snd = AnyCode; res.use_int = 1'b1;
          end else res.st = ST_PENDING;
        end else if (bad_common) res.st = ST_INVALID;
        else if (op_q == OP_SEND) begin
          if (!peer_proc) res.st = ST_INVALID;
          else begin
            res.emit = 1'b0; st_d = S_CHAIN; wk_start = 1'b1;
          end
        end else begin
          if (ipend_q[cidx] && (peer_q == AnyCode || peer_q == IntCode)) begin
            res.st = ST_DELIVERED; res.rcv = cidx; res.snd = AnyCode; res.use_int = 1'b1;
          end else if (peer_q == AnyCode && qhead_q[cidx] < Empty) begin
            res.emit = 1'b0; st_d = S_UNL; wk_start = 1'b1; wk_kind = WK_UNLINK;
            wk_first = qhead_q[cidx]; wk_key = qhead_q[cidx][PW-1:0];
          end else if (peer_proc && snd_q[pidx] && tgt_q[pidx] == cidx) begin
            res.emit = 1'b0; st_d = S_UNL; wk_start = 1'b1; wk_kind = WK_UNLINK;
            wk_first = qhead_q[cidx]; wk_key = pidx;
          end else res.st = ST_BLOCKED;
        end
      end
      S_CHAIN: if (wk_done) begin
        if (wk_hit) begin
          st_d = S_OUT; res.emit = 1'b1; res.st = ST_DEADLOCK;
        end else if (rcv_match_send) begin
          st_d = S_OUT; res.emit = 1'b1; res.st = ST_DELIVERED;
          res.rcv = pidx; res.snd = QW'(cidx); res.use_req = 1'b1;
        end else if (qhead_q[pidx] >= Empty) begin
          st_d = S_OUT; res.emit = 1'b1; res.st = ST_BLOCKED;
        end else begin
          st_d = S_TAIL; wk_start = 1'b1; wk_kind = WK_TAIL; wk_first = qhead_q[pidx];
        end
      end
      S_TAIL: if (wk_done) begin
        st_d = S_OUT; res.emit = 1'b1; res.st = ST_BLOCKED;
      end
      S_UNL: if (wk_done) begin
        st_d = S_OUT; res.emit = 1'b1; res.st = ST_DELIVERED;
        res.rcv = cidx; res.snd = QW'(who_q); res.use_held = 1'b1;
      end
      S_OUT: if (!ovalid_q) st_d = S_IDLE;
      default: st_d = S_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE; ovalid_q <= 1'b0;
      snd_q <= '0; rcv_q <= '0; ipend_q <= '0; hit_type_q <= TYPE_WIDTH'(1);
      for (int i = 0; i < PROC_COUNT; i++) begin
        qhead_q[i] <= Empty; qnext_q[i] <= Empty;
      end
    end else begin
      st_q <= st_d;
      if (cfg_we_i) hit_type_q <= cfg_wdata_i;
      if (rsp.valid && rsp.ready) ovalid_q <= 1'b0;
      if (res.emit) ovalid_q <= 1'b1;
      // state updates
      if (st_q == S_DEC && caller_ok && op_q != OP_BAD) begin
        if (op_q == OP_INT) begin
          if (int_wake) begin
            rcv_q[cidx] <= 1'b0; ipend_q[cidx] <= 1'b0;
          end else ipend_q[cidx] <= 1'b1;
        end else if (op_q == OP_RECV && !bad_common && res.emit) begin
          if (res.st == ST_DELIVERED) ipend_q[cidx] <= 1'b0;
          else rcv_q[cidx] <= 1'b1;
        end
      end
      if (st_q == S_CHAIN && wk_done && !wk_hit) begin
        if (rcv_match_send) rcv_q[pidx] <= 1'b0;
        else begin
          snd_q[cidx] <= 1'b1; qnext_q[cidx] <= Empty;
          if (qhead_q[pidx] >= Empty) qhead_q[pidx] <= QW'(cidx);
        end
      end
      if (st_q == S_TAIL && wk_done && wk_hit) qnext_q[wk_node[PW-1:0]] <= QW'(cidx);
      if (st_q == S_UNL && wk_done) begin
        snd_q[who_q] <= 1'b0;
        if (wk_hit) begin
          if (wk_prev >= Empty) qhead_q[cidx] <= qnext_q[who_q];
          else qnext_q[wk_prev[PW-1:0]] <= qnext_q[who_q];
          qnext_q[who_q] <= Empty;
        end
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (req.valid && req.ready) begin
      op_q <= req.operation; caller_raw_q <= req.caller; peer_q <= req.peer;
      ty_q <= req.message_type; da_q <= req.message_data;
    end
    if (wk_start && wk_kind == WK_UNLINK) who_q <= wk_key;
    if (st_q == S_DEC && caller_ok && op_q == OP_RECV && !bad_common && res.emit
        && res.st == ST_BLOCKED) rfrom_q[cidx] <= peer_q;
    if (st_q == S_CHAIN && wk_done && !wk_hit && !rcv_match_send) begin
      tgt_q[cidx] <= pidx; htype_q[cidx] <= ty_q; hdata_q[cidx] <= da_q;
    end
    if (res.emit) begin
      ost_q <= res.st; orcv_q <= res.rcv; osnd_q <= res.snd;
      if (res.use_int) begin
        oty_q <= hit_type_q; oda_q <= '0;
      end else if (res.use_req) begin
        oty_q <= ty_q; oda_q <= da_q;
      end else if (res.use_held) begin
        oty_q <= htype_q[who_q]; oda_q <= hdata_q[who_q];
      end else begin
        oty_q <= '0; oda_q <= '0;
      end
    end
  end

  assign rsp.valid    = ovalid_q;
  assign rsp.status   = ost_q;
  assign rsp.receiver = orcv_q;
  assign rsp.sender   = osnd_q;
  assign rsp.out_type = oty_q;
  assign rsp.out_data = oda_q;
endmodule

[sv/mre_checker.sv]
module mre_checker import mre_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       req_valid,
  input logic       req_ready,
  input logic       rsp_valid,
  input logic       rsp_ready,
  input logic [2:0] rsp_status
);
  a_no_accept_with_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid |-> !req_ready) else $error("request taken while result pending");
  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid |-> rsp_status <= ST_INVALID) else $error("bad status");
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_valid && req_ready) |=> !req_ready) else $error("ready after accept");
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid && !rsp_ready) |=> rsp_valid && $stable(rsp_status))
    else $error("result dropped");
endmodule

bind message_rendezvous_engine_core mre_checker u_chk (
  .clk_i(clk_i), .rst_ni(rst_ni),
  .req_valid(req.valid), .req_ready(req.ready),
  .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_status(rsp.status)
);

[bench/message_rendezvous_engine_core_test.sv]
module message_rendezvous_engine_core_test;
  import mre_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NPROC   = 8;
  localparam logic [3:0]  ANY     = 4'd8;
  localparam logic [3:0]  INTR    = 4'd9;
  localparam logic [3:0]  EMPTY   = 4'd8;
  localparam int unsigned LIMIT   = 200000;

  typedef struct packed {
    status_e     status;
    logic [2:0]  receiver;
    logic [3:0]  sender;
    logic [15:0] out_type;
    logic [31:0] out_data;
  } rendezvous_t;

  // Scoreboard: keeps its own copy of the rendezvous state and predicts
  // one outcome per request transfer.
  class rendezvous_board;
    logic        snd_busy [NPROC];
    logic        rcv_busy [NPROC];
    logic [2:0]  dest     [NPROC];
    logic [3:0]  want     [NPROC];
    logic [15:0] hold_ty  [NPROC];
    logic [31:0] hold_da  [NPROC];
    logic        irq      [NPROC];
    logic [3:0]  head     [NPROC];
    logic [3:0]  link     [NPROC];
    logic [15:0] irq_type;
    rendezvous_t pending_q[$];
    int          errors;
    int          delivered;
    int          deadlocks;
    int          irq_msgs;

    function new();
      errors = 0;
      delivered = 0;
      deadlocks = 0;
      irq_msgs = 0;
      irq_type = 16'd1;
      for (int i = 0; i < NPROC; i++) begin
        snd_busy[i] = 0; rcv_busy[i] = 0; irq[i] = 0;
        head[i] = EMPTY; link[i] = EMPTY;
        dest[i] = 0; want[i] = 0; hold_ty[i] = 0; hold_da[i] = 0;
      end
    endfunction

    function automatic bit bool_chain(int src, int dst);
      int p;
      p = dst;
      for (int s = 0; s < NPROC; s++) begin
        if (p >= NPROC || !snd_busy[p]) return 0;
        if (dest[p] == src) return 1;
        p = dest[p];
      end
      return 0;
    endfunction

    function automatic void append(int owner, int who);
      int p;
      int n;
      p = head[owner];
      link[who] = EMPTY;
      if (p >= NPROC) begin
        head[owner] = 4'(who);
        return;
      end
      for (int s = 0; s < NPROC; s++) begin
        n = link[p];
        if (n >= NPROC) begin
          link[p] = 4'(who);
          return;
        end
        p = n;
      end
    endfunction

    function automatic void unlink(int owner, int who);
      int p;
      int prev;
      p = head[owner];
      prev = EMPTY;
      for (int s = 0; s < NPROC && p < NPROC; s++) begin
        if (p == who) begin
          if (prev >= NPROC) head[owner] = link[p];
          else link[prev] = link[p];
          link[p] = EMPTY;
          return;
        end
        prev = p;
        p = link[p];
      end
    endfunction

    function automatic rendezvous_t outcome(status_e st, int r, int s, logic [15:0] t,
                                            logic [31:0] d);
      rendezvous_t o;
      o.status = st; o.receiver = 3'(r); o.sender = 4'(s); o.out_type = t; o.out_data = d;
      return o;
    endfunction

    function automatic rendezvous_t resolve(op_e op, int c, int p, logic [15:0] t,
                                            logic [31:0] d);
      int h;
      if (op == OP_BAD) return outcome(ST_INVALID, 0, 0, 0, 0);
      if (op == OP_INT) begin
        if (rcv_busy[c] && (want[c] == INTR || want[c] == ANY)) begin
          rcv_busy[c] = 0;
          irq[c] = 0;
          return outcome(ST_DELIVERED, c, NPROC, irq_type, 0);
        end
        irq[c] = 1;
        return outcome(ST_PENDING, 0, 0, 0, 0);
      end
      if (p > INTR || p == c || snd_busy[c] || rcv_busy[c])
        return outcome(ST_INVALID, 0, 0, 0, 0);
      if (op == OP_SEND) begin
        if (p >= NPROC) return outcome(ST_INVALID, 0, 0, 0, 0);
        if (bool_chain(c, p)) return outcome(ST_DEADLOCK, 0, 0, 0, 0);
        if (rcv_busy[p] && (want[p] == c || want[p] == ANY)) begin
          rcv_busy[p] = 0;
          return outcome(ST_DELIVERED, p, c, t, d);
        end
        snd_busy[c] = 1; dest[c] = 3'(p); hold_ty[c] = t; hold_da[c] = d;
        append(p, c);
        return outcome(ST_BLOCKED, 0, 0, 0, 0);
      end
      // receive side
      if (irq[c] && (p == ANY || p == INTR)) begin
        irq[c] = 0;
        return outcome(ST_DELIVERED, c, NPROC, irq_type, 0);
      end
      h = -1;
      if (p == ANY && head[c] < NPROC) h = head[c];
      else if (p < NPROC && snd_busy[p] && dest[p] == c) h = p;
      if (h >= 0) begin
        unlink(c, h);
        snd_busy[h] = 0;
        return outcome(ST_DELIVERED, c, h, hold_ty[h], hold_da[h]);
      end
      rcv_busy[c] = 1;
      want[c] = 4'(p);
      return outcome(ST_BLOCKED, 0, 0, 0, 0);
    endfunction

    function automatic void note_request(op_e op, int c, int p, logic [15:0] t,
                                         logic [31:0] d);
      pending_q.push_back(resolve(op, c, p, t, d));
    endfunction

    task automatic report(string what, int got, int exp);
      $display("mismatch %s: got %0d expected %0d", what, got, exp);
      errors++;
    endtask

    task automatic check_result(rendezvous_t got);
      rendezvous_t exp;
      if (pending_q.size() == 0) begin
        report("unexpected result, status", got.status, -1);
        return;
      end
      exp = pending_q.pop_front();
      if (got.status   != exp.status)   report("status", got.status, exp.status);
      if (got.receiver != exp.receiver) report("receiver", got.receiver, exp.receiver);
      if (got.sender   != exp.sender)   report("sender", got.sender, exp.sender);
      if (got.out_type != exp.out_type) report("out_type", got.out_type, exp.out_type);
      if (got.out_data != exp.out_data) report("out_data", got.out_data, exp.out_data);
      if (exp.status == ST_DELIVERED) delivered++;
      if (exp.status == ST_DELIVERED && exp.sender == NPROC) irq_msgs++;
      if (exp.status == ST_DEADLOCK) deadlocks++;
    endtask
  endclass

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        cfg_we_i = 0;
  logic [15:0] cfg_wdata_i = '0;
  int unsigned cycle = 0;
  int          sent = 0;
  int          results = 0;
  bit          rx_hold = 0;   // receiver held off for the long stall
  bit          rx_random = 1; // draw per-result gaps
  rendezvous_board board;

  mre_req_if req_ch ();
  mre_rsp_if rsp_ch ();

  message_rendezvous_engine_core uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .req        (req_ch.sink),
    .rsp        (rsp_ch.source)
  );

  always begin
    #2 clk_i = 1;
    #2 clk_i = 0;
  end

  initial begin
    req_ch.valid = 0;
    req_ch.operation = '0;
    req_ch.caller = '0;
    req_ch.peer = '0;
    req_ch.message_type = '0;
    req_ch.message_data = '0;
    rsp_ch.ready = 0;
    board = new();
  end

  // Watchdog: generous bound on the whole run.
  always @(posedge clk_i) begin
    cycle <= cycle + 1;
    if (cycle > LIMIT) begin
      $display("timeout after %0d cycles", cycle);
      $display("** message_rendezvous_engine_core: FAILED **");
      $finish;
    end
  end

  // Result side: sample each transfer, then redraw ready.
  always @(posedge clk_i) begin
    if (rst_ni && rsp_ch.valid && rsp_ch.ready) begin
      board.check_result({status_e'(rsp_ch.status), rsp_ch.receiver, rsp_ch.sender,
                          rsp_ch.out_type, rsp_ch.out_data});
      results <= results + 1;
    end
  end

  initial begin : result_ready
    int gap;
    @(posedge rst_ni);
    forever begin
      if (rx_hold) begin
        rsp_ch.ready <= 0;
        @(posedge clk_i);
      end else begin
        gap = rx_random ? $urandom_range(0, 3) : 0;
        if (gap == 0) begin
          rsp_ch.ready <= 1;
          @(posedge clk_i);
          while (!(rsp_ch.valid && rsp_ch.ready)) @(posedge clk_i);
        end else begin
          rsp_ch.ready <= 0;
          repeat (gap) @(posedge clk_i);
        end
      end
    end
  end

  // One request transfer; the expectation is noted as it is accepted.
  task automatic push_request(op_e op, int c, int p, logic [15:0] t, logic [31:0] d,
                              bit idle_gaps = 1);
    int gap;
    gap = idle_gaps ? $urandom_range(0, 3) : 0;
    if (gap > 0) begin
      req_ch.valid <= 0;
      repeat (gap) @(posedge clk_i);
    end
    req_ch.valid <= 1;
    req_ch.operation <= op;
    req_ch.caller <= 3'(c);
    req_ch.peer <= 4'(p);
    req_ch.message_type <= t;
    req_ch.message_data <= d;
    @(posedge clk_i);
    while (!req_ch.ready) @(posedge clk_i);
    board.note_request(op, c, p, t, d);
    sent++;
  endtask

  task automatic idle_request();
    req_ch.valid <= 0;
  endtask

  // Wait until every expectation has come back, plus a settle margin.
  task automatic drain();
    idle_request();
    @(posedge clk_i);
    while (board.pending_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic set_int_type(logic [15:0] v);
    cfg_we_i <= 1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 0;
    board.irq_type = v;
  endtask

  // Pick a peer that is mostly a real process, sometimes any/interrupt,
  // rarely an out-of-range code.
  function automatic int draw_peer();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(0, NPROC - 1);
    if (r < 82) return ANY;
    if (r < 94) return INTR;
    return $urandom_range(10, 15);
  endfunction

  function automatic op_e draw_op();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return OP_SEND;
    if (r < 88) return OP_RECV;
    if (r < 97) return OP_INT;
    return OP_BAD;
  endfunction

  task automatic random_phase(int n);
    op_e op;
    int  c;
    for (int i = 0; i < n; i++) begin
      op = draw_op();
      c = $urandom_range(0, NPROC - 1);
      push_request(op, c, draw_peer(), $urandom, $urandom);
    end
  endtask

  // Well-formed rendezvous pairs: a send and the matching receive.
  task automatic pairs_phase(int n);
    int a;
    int b;
    for (int i = 0; i < n; i++) begin
      a = $urandom_range(0, NPROC - 1);
      b = (a + $urandom_range(1, NPROC - 1)) % NPROC;
      if ($urandom_range(0, 1)) begin
        push_request(OP_SEND, a, b, $urandom, $urandom);
        push_request(OP_RECV, b, $urandom_range(0, 1) ? a : ANY, 0, 0);
      end else begin
        push_request(OP_RECV, b, $urandom_range(0, 1) ? a : ANY, 0, 0);
        push_request(OP_SEND, a, b, $urandom, $urandom);
      end
    end
  endtask

  initial begin : stimulus
    repeat (5) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // Directed: extremes, every op, each corner named by the spec.
    push_request(OP_BAD, 0, 0, 16'hffff, 32'hffff_ffff);
    push_request(OP_SEND, 0, 0, 0, 0);                   // self peer
    push_request(OP_SEND, 1, ANY, 0, 0);                 // send to any
    push_request(OP_SEND, 1, INTR, 0, 0);                // send to interrupt
    push_request(OP_RECV, 2, 15, 0, 0);                  // peer out of range
    push_request(OP_SEND, 7, 6, 16'hffff, 32'hffff_ffff); // 7 blocks on 6
    push_request(OP_SEND, 7, 5, 0, 0);                   // blocked caller
    push_request(OP_SEND, 6, 5, 16'h0000, 32'h0);        // 6 blocks on 5
    push_request(OP_SEND, 5, 7, 1, 1);                   // chain 7->6->5: deadlock
    push_request(OP_SEND, 4, 6, 16'h8001, 32'h8000_0001); // queue 6: 7,4
    push_request(OP_RECV, 6, 4, 0, 0);                   // caller 6 is blocked sending: invalid
    push_request(OP_RECV, 6, ANY, 0, 0);                 // caller 6 still blocked: invalid
    push_request(OP_RECV, 5, ANY, 0, 0);                 // 6
    push_request(OP_RECV, 3, INTR, 0, 0);                // blocks on interrupt
    push_request(OP_INT, 3, 0, 0, 0);                    // wakes 3
    push_request(OP_INT, 2, 0, 0, 0);                    // pending
    push_request(OP_RECV, 2, ANY, 0, 0);                 // takes pending
    push_request(OP_RECV, 1, ANY, 0, 0);                 // waits any
    push_request(OP_SEND, 0, 1, 16'h1234, 32'hdead_beef); // delivered at once
    push_request(OP_RECV, 1, 0, 0, 0);                   // blocks on 0
    push_request(OP_INT, 1, 0, 0, 0);                    // not for 1: pending
    push_request(OP_SEND, 0, 1, 16'h5678, 32'h0);        // direct to 1
    drain();

    set_int_type(16'hffff);
    random_phase(150);
    pairs_phase(60);
    drain();

    // Long receiver stall while requests keep coming; the block backs up.
    fork
      begin
        rx_hold = 1;
        repeat (300) @(posedge clk_i);
        rx_hold = 0;
      end
      random_phase(20);
    join
    drain();

    set_int_type(16'h0000);
    rx_random = 0;
    pairs_phase(50);
    random_phase(100);
    rx_random = 1;
    drain();

    set_int_type($urandom);
    for (int i = 0; i < 30; i++) begin
      push_request(OP_INT, $urandom_range(0, NPROC - 1), $urandom_range(0, 15),
                   $urandom, $urandom, 0);
      push_request(OP_RECV, $urandom_range(0, NPROC - 1), ANY, 0, 0, 0);
    end
    random_phase(130);
    drain();

    $display("covered %0d requests, %0d results: %0d deliveries (%0d interrupt),",
             sent, results, board.delivered, board.irq_msgs);
    $display("%0d deadlock refusals, several interrupt types, long output stall",
             board.deadlocks);
    if (board.errors == 0 && board.pending_q.size() == 0) begin
      $display("** message_rendezvous_engine_core: PASSED **");
    end else begin
      $display("** message_rendezvous_engine_core: FAILED **");
    end
    $finish;
  end

endmodule
